/* rtl/lfsq_pkg.sv */
`default_nettype none
package lfsq_pkg;

  localparam int SIZE_W = 13;
  localparam int POS_W = 12;
  localparam int GW_W = 13;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam int GRID_WIDTH_RESET = 4096;

  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [GW_W-1:0] gw_t;

  localparam size_t SIZE_MAX = '1;

  // register index taken from paddr[2]
  localparam logic REG_GRID_WIDTH = 1'b0;

  typedef struct packed {
    logic  found;
    size_t best_size;
    pos_t  best_row;
    pos_t  best_col;
  } result_t;

endpackage
`default_nettype wire

/* rtl/lfsq_if.sv */
`default_nettype none
interface lfsq_cell_if;
  logic valid;
  logic ready;
  logic cell_free;
  logic last_cell;

  modport source (output valid, output cell_free, output last_cell, input ready);
  modport sink (input valid, input cell_free, input last_cell, output ready);
endinterface

interface lfsq_result_if;
  logic valid;
  logic ready;
  logic found;
  lfsq_pkg::size_t best_size;
  lfsq_pkg::pos_t best_row;
  lfsq_pkg::pos_t best_col;

  modport source (output valid, output found, output best_size, output best_row,
                  output best_col, input ready);
  modport sink (input valid, input found, input best_size, input best_row,
                input best_col, output ready);
endinterface
`default_nettype wire

/* rtl/lfsq_cfg.sv */
`default_nettype none
module lfsq_cfg #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lfsq_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [lfsq_pkg::DATA_W-1:0]   pwdata,
  output logic      [lfsq_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output logic      [$clog2(MAX_WIDTH)-1:0]  last_col
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WCMP = (CW + 1 > lfsq_pkg::GW_W) ? CW + 1 : lfsq_pkg::GW_W;
  localparam int RESET_EFF = (MAX_WIDTH < lfsq_pkg::GRID_WIDTH_RESET) ?
                             MAX_WIDTH : lfsq_pkg::GRID_WIDTH_RESET;

  lfsq_pkg::gw_t grid_width;
  lfsq_pkg::gw_t wr_width;
  logic [WCMP-1:0] wr_ext;
  logic [WCMP-1:0] wr_eff;
  logic [CW-1:0] last_col_next;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && (paddr[2] == lfsq_pkg::REG_GRID_WIDTH);
  assign wr_width = pwdata[lfsq_pkg::GW_W-1:0];
  assign wr_ext = WCMP'(wr_width);

  // clamp to 1..MAX_WIDTH
  always_comb begin
    priority if (wr_ext == '0) begin
      wr_eff = WCMP'(1);
    end else if (wr_ext > WCMP'(MAX_WIDTH)) begin
      wr_eff = WCMP'(MAX_WIDTH);
    end else begin
      wr_eff = wr_ext;
    end
    last_col_next = CW'(wr_eff - WCMP'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= lfsq_pkg::GW_W'(lfsq_pkg::GRID_WIDTH_RESET);
      last_col <= CW'(RESET_EFF - 1);
    end else if (wr_en) begin
      grid_width <= wr_width;
      last_col <= last_col_next;
    end
  end

  always_comb begin
    if (paddr[2] == lfsq_pkg::REG_GRID_WIDTH) begin
      prdata = lfsq_pkg::DATA_W'(grid_width);
    end else begin
      prdata = '0;
    end
  end

endmodule
`default_nettype wire

/* rtl/lfsq_core.sv */
`default_nettype none
module lfsq_core #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  last_col,
  lfsq_cell_if.sink                          grid_cell,
  lfsq_result_if.source                      result
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // line store of the previous row's square sizes
  lfsq_pkg::size_t line_mem [MAX_WIDTH];
  lfsq_pkg::size_t rdata;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic accept;
  logic row_end;

  logic s1_valid;
  logic s1_free;
  logic s1_last;
  logic s1_first;
  logic s1_row_end;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic s1_fwd;
  lfsq_pkg::size_t s1_fwd_size;
  logic s1_adv;

  lfsq_pkg::size_t left_size;
  lfsq_pkg::size_t diag_size;
  lfsq_pkg::size_t best_size;
  lfsq_pkg::pos_t best_row;
  lfsq_pkg::pos_t best_col;

  lfsq_pkg::size_t top;
  lfsq_pkg::size_t min3;
  lfsq_pkg::size_t size;
  lfsq_pkg::result_t nb;
  lfsq_pkg::result_t res;
  logic res_valid;

  assign accept = grid_cell.valid && grid_cell.ready;
  assign row_end = (col >= last_col);
  assign s1_adv = s1_valid && (!s1_last || !res_valid || result.ready);
  assign grid_cell.ready = !s1_valid || s1_adv;

  // stage 0: position counters and line store read
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (grid_cell.last_cell) begin
        col <= '0;
        row <= '0;
      end else if (row_end) begin
        col <= '0;
        if (row < RW'(MAX_HEIGHT - 1)) begin
          row <= row + RW'(1);
        end
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= line_mem[col];
    end
    if (s1_adv) begin
      line_mem[s1_col] <= size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_free <= grid_cell.cell_free;
      s1_last <= grid_cell.last_cell;
      s1_first <= (row == '0) || (col == '0);
      s1_row_end <= row_end;
      s1_col <= col;
      s1_row <= row;
      // read and write of the same entry in one cycle: take the new size
      s1_fwd <= s1_adv && (s1_col == col);
      s1_fwd_size <= size;
    end
  end

  // stage 1: square size from top, left and diagonal
  always_comb begin
    top = s1_fwd ? s1_fwd_size : rdata;
    min3 = top;
    if (left_size < min3) begin
      min3 = left_size;
    end
    if (diag_size < min3) begin
      min3 = diag_size;
    end
    priority if (!s1_free) begin
      size = '0;
    end else if (s1_first) begin
      size = lfsq_pkg::size_t'(1);
    end else if (min3 == lfsq_pkg::SIZE_MAX) begin
      size = lfsq_pkg::SIZE_MAX;
    end else begin
      size = min3 + lfsq_pkg::size_t'(1);
    end
  end

  always_comb begin
    if (size > best_size) begin
      nb.best_size = size;
      nb.best_row = lfsq_pkg::POS_W'(s1_row);
      nb.best_col = lfsq_pkg::POS_W'(s1_col);
    end else begin
      nb.best_size = best_size;
      nb.best_row = best_row;
      nb.best_col = best_col;
    end
    nb.found = (nb.best_size != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_size <= '0;
      diag_size <= '0;
      best_size <= '0;
      best_row <= '0;
      best_col <= '0;
    end else if (s1_adv) begin
      if (s1_row_end || s1_last) begin
        left_size <= '0;
        diag_size <= '0;
      end else begin
        left_size <= size;
        diag_size <= top;
      end
      if (s1_last) begin
        best_size <= '0;
        best_row <= '0;
        best_col <= '0;
      end else begin
        best_size <= nb.best_size;
        best_row <= nb.best_row;
        best_col <= nb.best_col;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      res <= nb;
    end
  end

  assign result.valid = res_valid;
  assign result.found = res.found;
  assign result.best_size = res.best_size;
  assign result.best_row = res.best_row;
  assign result.best_col = res.best_col;

endmodule
`default_nettype wire

/* rtl/largest_free_square_finder.sv */
// largest free square finder
// cell channel (valid/ready): one grid cell per transaction in raster order,
// cell_free marks an empty cell, last_cell marks the final cell of the grid.
// result channel (valid/ready): one transaction per grid, sent after the
// last cell, with the side of the largest all-free square and the row and
// column of its bottom-right cell; found is low when no cell was free.
// apb port: register grid_width at address 0 sets the cells per row; write
// it only while no grid is in flight.
// throughput: one cell per clock, except that a last cell waits while the
// previous result is not taken; a cell is read from the line store in the
// accept cycle, its size is formed and written back as stage 1 advances.
// the result enters its output register as the last cell leaves stage 1;
// a stalled result holds in its output register; cells keep flowing until
// the following last cell, which waits until the result has been taken.
// reset clears the counters and running best, sets grid_width to 4096; the
// line store needs no clearing since each row is written before it is read.
`default_nettype none
module largest_free_square_finder #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lfsq_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lfsq_pkg::DATA_W-1:0]  pwdata,
  output logic      [lfsq_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  lfsq_cell_if.sink                         grid_cell,
  lfsq_result_if.source                     result
);

  logic [$clog2(MAX_WIDTH)-1:0] last_col;

  lfsq_cfg #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .last_col(last_col)
  );

  lfsq_core #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .last_col(last_col),
    .grid_cell(grid_cell),
    .result(result)
  );

endmodule
`default_nettype wire
